// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

  localparam logic [2:0] OP_ADD_FRONT    = 3'd0;
  localparam logic [2:0] OP_ADD_BACK     = 3'd1;
  localparam logic [2:0] OP_REMOVE_FRONT = 3'd2;
  localparam logic [2:0] OP_REMOVE_BACK  = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT   = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK    = 3'd5;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // what every cell of the chain does at a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_PUT
  } cell_op_t;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// double-ended queue of data words held in a chain of cells
// input: in_opcode / in_value are taken at a clock edge with start high and
//   busy low; opcodes add front, add back, remove front, remove back,
//   peek front, peek back (six and seven do nothing but report)
// output: every transaction gives one result on out_value, out_error_code,
//   out_is_empty and out_entry_count, shown for one cycle with out_valid high
//   in the cycle after the transaction completes; the receiver cannot stall
// the front word always sits in cell zero, the others follow in order
// timing: adds, front operations and no-ops show their result in the cycle
//   after acceptance, so one can be accepted every cycle while busy is low;
//   a back remove or back peek on a non-empty queue keeps busy high through
//   ST_WAIT, which counts down the entries held when accepted, a wait that
//   covers the back word's trip down the relay path, and then ST_EXEC
// errors: add on a full queue or read on an empty one leaves the state alone
//   and reports an error code with out_value zero
// reset (synchronous, rst_n low): the queue is emptied, busy and out_valid
//   drop; stored words are not cleared and are never read before written
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_opcode,
  input  logic [DATA_WIDTH-1:0]        in_value,
  output logic                         out_valid,
  output logic [DATA_WIDTH-1:0]        out_value,
  output logic [1:0]                   out_error_code,
  output logic                         out_is_empty,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EXEC
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         wait_r, wait_nxt;
  logic                  remove_r, remove_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [1:0]            out_error_code_r, out_error_code_nxt;

  cell_op_t              cell_op;
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_relay [DEPTH];

  logic                  full, empty;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    wait_nxt           = wait_r;
    remove_nxt         = remove_r;
    out_valid_nxt      = 1'b0;
    out_value_nxt      = '0;
    out_error_code_nxt = ERR_OK;
    cell_op            = CELL_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          unique case (in_opcode) inside
            OP_ADD_FRONT, OP_ADD_BACK: begin
              if (full) begin
                out_error_code_nxt = ERR_FULL;
              end else begin
                cell_op   = (in_opcode == OP_ADD_FRONT) ? CELL_SHIFT_R : CELL_PUT;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_REMOVE_FRONT, OP_PEEK_FRONT: begin
              if (empty) begin
                out_error_code_nxt = ERR_EMPTY;
              end else begin
                out_value_nxt = cell_data[0];
                if (in_opcode == OP_REMOVE_FRONT) begin
                  cell_op   = CELL_SHIFT_L;
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            OP_REMOVE_BACK, OP_PEEK_BACK: begin
              if (empty) begin
                out_error_code_nxt = ERR_EMPTY;
              end else begin
                // let the back word reach cell zero before reading it
                out_valid_nxt = 1'b0;
                wait_nxt      = count_r;
                remove_nxt    = (in_opcode == OP_REMOVE_BACK);
                state_nxt     = ST_WAIT;
              end
            end
            default: out_value_nxt = '0;
          endcase
        end
      end
      ST_WAIT: begin
        wait_nxt = wait_r - 1'b1;
        if (wait_r == CW'(1)) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = cell_relay[0];
        if (remove_r) count_nxt = count_r - 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      remove_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      remove_r    <= remove_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r      <= out_value_nxt;
    out_error_code_r <= out_error_code_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w, relay_w;

    if (i == 0) begin : g_first
      assign left_w = in_value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
      assign relay_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
      assign relay_w = cell_relay[i+1];
    end

    dq_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op),
      .count    (count_r),
      .ins      (in_value),
      .left_in  (left_w),
      .right_in (right_w),
      .relay_in (relay_w),
      .data     (cell_data[i]),
      .relay    (cell_relay[i])
    );
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_error_code  = out_error_code_r;
  assign out_is_empty    = (count_r == '0);
  assign out_entry_count = count_r;

endmodule

// ===== rtl/core/dq_cell.sv =====
module dq_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5
) (
  input  logic                  clk,
  input  dq_pkg::cell_op_t      op,
  input  logic [CW-1:0]         count,
  input  logic [DATA_WIDTH-1:0] ins,
  input  logic [DATA_WIDTH-1:0] left_in,
  input  logic [DATA_WIDTH-1:0] right_in,
  input  logic [DATA_WIDTH-1:0] relay_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] relay
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [DATA_WIDTH-1:0] relay_r, relay_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op)
      CELL_SHIFT_R: data_nxt = left_in;
      CELL_SHIFT_L: data_nxt = right_in;
      CELL_PUT: begin
        if (count == CW'(IDX)) data_nxt = ins;
      end
      default: data_nxt = data_r;
    endcase
  end

  // the back word walks toward cell zero, one cell a cycle
  assign relay_nxt = (count == CW'(IDX + 1)) ? data_r : relay_in;

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    relay_r <= relay_nxt;
  end

  assign data  = data_r;
  assign relay = relay_r;

endmodule

// ===== rtl/core/dq_checker.sv =====
module dq_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [2:0]                 in_opcode,
  input logic                       out_valid,
  input logic [DATA_WIDTH-1:0]      out_value,
  input logic [1:0]                 out_error_code,
  input logic                       out_is_empty,
  input logic [$clog2(DEPTH+1)-1:0] out_entry_count
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // a failed transaction returns no data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_OK) |-> (out_value == '0))
    else $error("error result carries data");

  // full error only when the queue is at capacity
  a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code == ERR_FULL) |-> (out_entry_count == CW'(DEPTH)))
    else $error("full error below capacity");

  // anything but a back read answers in the next cycle
  a_front_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode != OP_REMOVE_BACK && in_opcode != OP_PEEK_BACK)
      |=> out_valid)
    else $error("missing one-cycle result");

  // a back read on a non-empty queue holds the block busy
  a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !out_is_empty &&
     (in_opcode == OP_REMOVE_BACK || in_opcode == OP_PEEK_BACK))
      |=> (busy && !out_valid))
    else $error("back read did not occupy the block");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (.*);

// ===== tb/double_ended_queue_test.sv =====
`timescale 1ns / 1ps

module double_ended_queue_test;
  import dq_pkg::*;

  localparam int DQ_DEPTH = 16;
  localparam int DQ_WIDTH = 32;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [DQ_WIDTH-1:0] value;
    logic [1:0]          err;
    logic                empty;
    logic [4:0]          count;
  } dq_result_t;

  typedef struct {
    logic [2:0]          op;
    logic [DQ_WIDTH-1:0] word;
    bit                  typed;
    dq_result_t          want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [2:0]          in_opcode;
  logic [DQ_WIDTH-1:0] in_value;
  logic                out_valid;
  logic [DQ_WIDTH-1:0] out_value;
  logic [1:0]          out_error_code;
  logic                out_is_empty;
  logic [4:0]          out_entry_count;

  // shadow copy of the deque
  logic [DQ_WIDTH-1:0] shadow_store [DQ_DEPTH];
  logic [3:0]          shadow_front;
  logic [4:0]          shadow_count;

  dq_result_t pending_results [$];
  stim_row_t  stim_table [$];
  int         mismatch_count;
  bit         no_gaps;

  double_ended_queue #(
    .DEPTH      (DQ_DEPTH),
    .DATA_WIDTH (DQ_WIDTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_error_code  (out_error_code),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic dq_result_t deque_step(input logic [2:0] op, input logic [DQ_WIDTH-1:0] word);
    dq_result_t r;
    logic [3:0] back_idx;
    logic [3:0] tail_idx;
    r = '0;
    back_idx = shadow_front + shadow_count[3:0] - 4'd1;
    tail_idx = shadow_front + shadow_count[3:0];
    if ((op == OP_ADD_FRONT || op == OP_ADD_BACK) && shadow_count == DQ_DEPTH) begin
      r.err = ERR_FULL;
    end else if (op >= OP_REMOVE_FRONT && op <= OP_PEEK_BACK && shadow_count == 0) begin
      r.err = ERR_EMPTY;
    end else begin
      case (op)
        OP_ADD_FRONT: begin
          shadow_front = shadow_front - 4'd1;
          shadow_store[shadow_front] = word;
          shadow_count++;
        end
        OP_ADD_BACK: begin
          shadow_store[tail_idx] = word;
          shadow_count++;
        end
        OP_REMOVE_FRONT: begin
          r.value = shadow_store[shadow_front];
          shadow_front = shadow_front + 4'd1;
          shadow_count--;
        end
        OP_REMOVE_BACK: begin
          r.value = shadow_store[back_idx];
          shadow_count--;
        end
        OP_PEEK_FRONT: r.value = shadow_store[shadow_front];
        OP_PEEK_BACK:  r.value = shadow_store[back_idx];
        default: ;
      endcase
    end
    r.empty = (shadow_count == 0);
    r.count = shadow_count;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [DQ_WIDTH-1:0] word,
                                  input bit typed, input dq_result_t want);
    stim_row_t row;
    row.op = op;
    row.word = word;
    row.typed = typed;
    row.want = want;
    stim_table.push_back(row);
  endfunction

  function automatic logic [2:0] pick_opcode(input int add_percent);
    if ($urandom_range(0, 99) < 3) return 3'($urandom_range(OP_UNUSED_6, OP_UNUSED_7));
    if ($urandom_range(0, 99) < add_percent)
      return $urandom_range(0, 1) ? OP_ADD_BACK : OP_ADD_FRONT;
    return 3'($urandom_range(OP_REMOVE_FRONT, OP_PEEK_BACK));
  endfunction

  // returns in the time step of the edge that accepts the transaction
  task automatic drive_item(input logic [2:0] op, input logic [DQ_WIDTH-1:0] word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_value <= word;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(input logic [2:0] op, input logic [DQ_WIDTH-1:0] word,
                       input bit typed, input dq_result_t want);
    dq_result_t predicted;
    drive_item(op, word);
    predicted = deque_step(op, word);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    dq_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no transaction outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value)
          flag_mismatch($sformatf("out_value %h, want %h", out_value, exp_res.value));
        if (out_error_code !== exp_res.err)
          flag_mismatch($sformatf("out_error_code %0d, want %0d", out_error_code, exp_res.err));
        if (out_is_empty !== exp_res.empty)
          flag_mismatch($sformatf("out_is_empty %b, want %b", out_is_empty, exp_res.empty));
        if (out_entry_count !== exp_res.count)
          flag_mismatch($sformatf("out_entry_count %0d, want %0d",
                                  out_entry_count, exp_res.count));
      end
    end
  end

  initial begin
    int add_percent;
    int settle;
    logic [2:0] op;
    logic [DQ_WIDTH-1:0] word;

    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ADD_FRONT;
    in_value = '0;
    mismatch_count = 0;
    no_gaps = 1'b0;
    shadow_front = '0;
    shadow_count = '0;
    for (int i = 0; i < DQ_DEPTH; i++) shadow_store[i] = '0;

    // empty queue reads, unused opcodes, both ends and the full queue
    add_row(OP_PEEK_FRONT, 32'h1234_5678, 1, '{'0, ERR_EMPTY, 1'b1, 5'd0});
    add_row(OP_REMOVE_BACK, '1, 1, '{'0, ERR_EMPTY, 1'b1, 5'd0});
    add_row(OP_UNUSED_7, '1, 1, '{'0, ERR_OK, 1'b1, 5'd0});
    add_row(OP_ADD_BACK, '1, 1, '{'0, ERR_OK, 1'b0, 5'd1});
    add_row(OP_ADD_FRONT, '0, 1, '{'0, ERR_OK, 1'b0, 5'd2});
    add_row(OP_PEEK_BACK, '0, 1, '{'1, ERR_OK, 1'b0, 5'd2});
    add_row(OP_REMOVE_FRONT, '0, 1, '{'0, ERR_OK, 1'b0, 5'd1});
    add_row(OP_REMOVE_BACK, '0, 1, '{'1, ERR_OK, 1'b1, 5'd0});
    add_row(OP_REMOVE_FRONT, '0, 1, '{'0, ERR_EMPTY, 1'b1, 5'd0});
    for (int i = 0; i < DQ_DEPTH; i++)
      add_row((i % 2) ? OP_ADD_FRONT : OP_ADD_BACK, 32'hA5A5_0000 | i, 0, '0);
    add_row(OP_ADD_FRONT, 32'hDEAD_BEEF, 1, '{'0, ERR_FULL, 1'b0, 5'd16});
    add_row(OP_UNUSED_6, '0, 1, '{'0, ERR_OK, 1'b0, 5'd16});
    add_row(OP_PEEK_FRONT, '0, 0, '0);
    add_row(OP_REMOVE_BACK, '0, 0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i])
      issue(stim_table[i].op, stim_table[i].word, stim_table[i].typed, stim_table[i].want);

    add_percent = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // drift between filling, draining and balanced phases
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: add_percent = 85;
          1: add_percent = 15;
          default: add_percent = 50;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      op = pick_opcode(add_percent);
      case ($urandom_range(0, 7))
        0: word = '0;
        1: word = '1;
        default: word = $urandom();
      endcase
      issue(op, word, 0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    settle = DRAIN_CYCLES;
    repeat (settle) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue.sv
rtl/core/dq_checker.sv
tb/double_ended_queue_test.sv
